@@ rtl/perceptron_predict_train_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the perceptron block
// Concurrent checks, sampled on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_PREDICT_TRAIN_TOP_DEFINES_SVH
`define PERCEPTRON_PREDICT_TRAIN_TOP_DEFINES_SVH

// cond holds in the same cycle as trig
`define PPT_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// cond holds in the cycle after trig
`define PPT_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

@@ rtl/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Sizes, register codes and saturation helper for the perceptron block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int IDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNT_W  = $clog2(MAX_FEATURES + 2);
    localparam int FC_W   = 7;
    localparam int LR_W   = 16;
    localparam int X_W    = 16;
    localparam int W_W    = 32;
    localparam int STEP_W = LR_W + 1;
    localparam int PROD_W = W_W + X_W;
    localparam int SUM_W  = 56;
    localparam int FRAC_SHIFT = 12;    // Q15.16 * Q3.12 -> Q19.28, summed in Q27.28

    localparam logic REG_FEATURE_COUNT = 1'b0;
    localparam logic REG_LEARNING_RATE = 1'b1;

    localparam logic [FC_W-1:0] FC_RESET = 7'd2;
    localparam logic [LR_W-1:0] LR_RESET = 16'd6554;

    // clamp a 34-bit sum to 32-bit signed
    function automatic logic signed [W_W-1:0] sat_w(input logic signed [W_W+1:0] s);
        logic signed [W_W-1:0] r;
        if (!s[W_W+1] && (s[W_W:W_W-1] != 2'b00))
        begin
            r = {1'b0, {(W_W-1){1'b1}}};
        end
        else if (s[W_W+1] && (s[W_W:W_W-1] != 2'b11))
        begin
            r = {1'b1, {(W_W-1){1'b0}}};
        end
        else
        begin
            r = s[W_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/perceptron_predict_train_top.sv @@
// ----------------------------------------------------------------------------
// perceptron_predict_train_top - single-layer perceptron, predict and train
// Feature word: taken in IDLE, multiplied in MUL before the next is taken.
// Last word: SUM, DECIDE, OUT; a result still in the output register holds it
// in OUT. Training: URD/UMUL/UWR per weight, then BIAS; one shared multiplier.
// Reset: weights and bias read as zero at once (per-entry valid bits).
// ----------------------------------------------------------------------------
`default_nettype none

`include "perceptron_predict_train_top_defines.svh"

module perceptron_predict_train_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] feature, [16] label
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tuser,   // [0] command

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] prediction, [1] length_error
);

    localparam int IDX_W  = ppt_pkg::IDX_W;
    localparam int CNT_W  = ppt_pkg::CNT_W;
    localparam int FC_W   = ppt_pkg::FC_W;
    localparam int LR_W   = ppt_pkg::LR_W;
    localparam int X_W    = ppt_pkg::X_W;
    localparam int W_W    = ppt_pkg::W_W;
    localparam int STEP_W = ppt_pkg::STEP_W;
    localparam int PROD_W = ppt_pkg::PROD_W;
    localparam int SUM_W  = ppt_pkg::SUM_W;
    localparam int SH     = ppt_pkg::FRAC_SHIFT;
    localparam int DEPTH  = ppt_pkg::MAX_FEATURES;

    // Sequencer:
    //   IDLE   take a word, issue weight read, buffer the feature
    //   MUL    product = w * x (added to the sum in the next IDLE)
    //   SUM    last word: fold in the final product
    //   DECIDE add bias, step activation, length check
    //   OUT    hand result to the output register
    //   URD/UMUL/UWR  per-weight update pass, BIAS  bias update
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_DECIDE, S_OUT, S_URD, S_UMUL, S_UWR, S_BIAS
    } state_t;

    state_t state_reg, state_next;

    // config
    logic [FC_W-1:0] fc_reg, fc_next;
    logic [LR_W-1:0] lr_reg, lr_next;

    // sample bookkeeping
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [W_W-1:0]   bias_reg, bias_next;
    logic [DEPTH-1:0]        wvalid_reg, wvalid_next;

    // per-word latches
    logic signed [X_W-1:0]   x_reg, x_next;
    logic                    cmd_reg, cmd_next;
    logic                    label_reg, label_next;
    logic                    last_reg, last_next;
    logic                    in_rng_reg, in_rng_next;
    logic                    acc_pend_reg, acc_pend_next;

    // shared multiplier output register
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // decision / training
    logic                     pred_reg, pred_next;
    logic                     lerr_reg, lerr_next;
    logic                     train_reg, train_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]         upd_idx_reg, upd_idx_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [1:0] m_data_reg, m_data_next;

    // memories
    logic signed [W_W-1:0] wmem [DEPTH];
    logic signed [X_W-1:0] smem [DEPTH];
    logic signed [W_W-1:0] w_rd_reg;
    logic                  wv_rd_reg;
    logic signed [X_W-1:0] s_rd_reg;

    logic [IDX_W-1:0]      w_raddr;
    logic                  w_we;
    logic signed [W_W-1:0] w_wdata;
    logic                  s_we;

    // datapath helpers
    logic                     cfg_wr;
    logic                     s_acc;
    logic signed [W_W-1:0]    w_eff;
    logic signed [W_W-1:0]    mul_a;
    logic signed [X_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [SUM_W-1:0]  total;
    logic signed [W_W+1:0]    rnd;
    logic signed [W_W+1:0]    delta;
    logic signed [STEP_W-1:0] step_new;
    logic                     idx_end;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_data_reg};

    always_comb
    begin
        unique case (paddr[2])
            ppt_pkg::REG_FEATURE_COUNT: prdata = {{(32-FC_W){1'b0}}, fc_reg};
            ppt_pkg::REG_LEARNING_RATE: prdata = {{(32-LR_W){1'b0}}, lr_reg};
            default:                    prdata = '0;
        endcase
    end

    // weights never written read as zero
    assign w_eff = wv_rd_reg ? w_rd_reg : '0;

    // one multiplier: w*x while summing, step*x while training
    assign mul_a = (state_reg == S_UMUL) ? W_W'(step_reg) : w_eff;
    assign mul_b = (state_reg == S_UMUL) ? s_rd_reg : x_reg;
    assign mul_p = mul_a * mul_b;

    assign total = sum_reg + {{(SUM_W-W_W-SH){bias_reg[W_W-1]}}, bias_reg, {SH{1'b0}}};

    // round to nearest Q15.16, ties up: floor((p + 2048) / 4096)
    assign rnd   = prod_reg[W_W+1:0] + (W_W+2)'(2048);
    assign delta = rnd >>> SH;

    assign step_new = label_reg ? $signed({1'b0, lr_reg}) : -$signed({1'b0, lr_reg});
    assign idx_end  = (32'(upd_idx_reg) + 32'd1) == 32'(fc_reg);

    assign w_raddr = (state_reg == S_IDLE) ? cnt_reg[IDX_W-1:0] : upd_idx_reg;
    assign s_we    = s_acc && (32'(cnt_reg) < DEPTH);
    assign w_we    = (state_reg == S_UWR);
    assign w_wdata = ppt_pkg::sat_w({{2{w_eff[W_W-1]}}, w_eff} + delta);

    always_comb
    begin
        state_next    = state_reg;
        fc_next       = fc_reg;
        lr_next       = lr_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        bias_next     = bias_reg;
        wvalid_next   = wvalid_reg;
        x_next        = x_reg;
        cmd_next      = cmd_reg;
        label_next    = label_reg;
        last_next     = last_reg;
        in_rng_next   = in_rng_reg;
        acc_pend_next = acc_pend_reg;
        prod_next     = prod_reg;
        pred_next     = pred_reg;
        lerr_next     = lerr_reg;
        train_next    = train_reg;
        step_next     = step_reg;
        upd_idx_next  = upd_idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (cfg_wr)
        begin
            if (paddr[2] == ppt_pkg::REG_FEATURE_COUNT)
            begin
                fc_next = pwdata[FC_W-1:0];
            end
            else
            begin
                lr_next = pwdata[LR_W-1:0];
            end
        end

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_pend_reg)
                begin
                    sum_next      = sum_reg + SUM_W'(prod_reg);
                    acc_pend_next = 1'b0;
                end
                if (s_acc)
                begin
                    x_next      = s_axis_tdata[X_W-1:0];
                    label_next  = s_axis_tdata[X_W];
                    cmd_next    = s_axis_tuser;
                    last_next   = s_axis_tlast;
                    in_rng_next = (32'(cnt_reg) < DEPTH);
                    if (32'(cnt_reg) <= DEPTH)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = mul_p;
                if (last_reg)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    acc_pend_next = in_rng_reg;
                    state_next    = S_IDLE;
                end
            end
            S_SUM:
            begin
                if (in_rng_reg)
                begin
                    sum_next = sum_reg + SUM_W'(prod_reg);
                end
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                pred_next = !total[SUM_W-1];
                lerr_next = (fc_reg == '0) || (32'(fc_reg) > DEPTH) ||
                            (32'(cnt_reg) != 32'(fc_reg));
                train_next = cmd_reg && !lerr_next && (pred_next != label_reg);
                step_next  = step_new;
                cnt_next   = '0;
                sum_next   = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {lerr_reg, pred_reg};
                    upd_idx_next = '0;
                    state_next   = train_reg ? S_URD : S_IDLE;
                end
            end
            S_URD:
            begin
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                prod_next  = mul_p;
                state_next = S_UWR;
            end
            S_UWR:
            begin
                wvalid_next[upd_idx_reg] = 1'b1;
                if (idx_end)
                begin
                    state_next = S_BIAS;
                end
                else
                begin
                    upd_idx_next = upd_idx_reg + IDX_W'(1);
                    state_next   = S_URD;
                end
            end
            S_BIAS:
            begin
                bias_next  = ppt_pkg::sat_w({{2{bias_reg[W_W-1]}}, bias_reg} +
                                            (W_W+2)'(step_reg));
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fc_reg       <= ppt_pkg::FC_RESET;
            lr_reg       <= ppt_pkg::LR_RESET;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            bias_reg     <= '0;
            wvalid_reg   <= '0;
            acc_pend_reg <= 1'b0;
            train_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fc_reg       <= fc_next;
            lr_reg       <= lr_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            bias_reg     <= bias_next;
            wvalid_reg   <= wvalid_next;
            acc_pend_reg <= acc_pend_next;
            train_reg    <= train_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        cmd_reg     <= cmd_next;
        label_reg   <= label_next;
        last_reg    <= last_next;
        in_rng_reg  <= in_rng_next;
        prod_reg    <= prod_next;
        pred_reg    <= pred_next;
        lerr_reg    <= lerr_next;
        step_reg    <= step_next;
        upd_idx_reg <= upd_idx_next;
        m_data_reg  <= m_data_next;
    end

    // weight store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[upd_idx_reg] <= w_wdata;
        end
        w_rd_reg  <= wmem[w_raddr];
        wv_rd_reg <= wvalid_reg[w_raddr];
    end

    // sample buffer: written per word, read during the update pass
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[cnt_reg[IDX_W-1:0]] <= s_axis_tdata[X_W-1:0];
        end
        s_rd_reg <= smem[upd_idx_reg];
    end

    // a pending product is only ever folded in from IDLE
    `PPT_ASSERT_SAME(a_pend_idle, state_reg != S_IDLE && state_reg != S_MUL, !acc_pend_reg)
    // the update pass runs on a cleared sample count and within feature_count
    `PPT_ASSERT_SAME(a_upd_bounds, state_reg == S_UWR, cnt_reg == '0 && 32'(upd_idx_reg) < 32'(fc_reg))
    // a result leaves OUT only through the output register
    `PPT_ASSERT_NEXT(a_out_load, state_reg == S_OUT && (!m_valid_reg || m_axis_tready), m_valid_reg)

endmodule

`default_nettype wire

@@ test/perceptron_predict_train_top_tb.sv @@
// ----------------------------------------------------------------------------
// perceptron_predict_train_top_tb - regression bench for the perceptron block
// Streams feature words with random gaps and output back-pressure, predicts
// every class and length flag in a scoreboard that also tracks the weights,
// and compares each result word field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module perceptron_predict_train_top_tb;

    localparam int     MAX_FEATURES  = ppt_pkg::MAX_FEATURES;
    localparam int     W_W           = ppt_pkg::W_W;
    localparam int     X_W           = ppt_pkg::X_W;
    localparam int     FC_W          = ppt_pkg::FC_W;
    localparam int     LR_W          = ppt_pkg::LR_W;

    localparam int     HALF_PERIOD   = 5;
    localparam int     RESET_CYCLES  = 6;
    // margin for the result, a full update pass over every weight and the bias
    localparam int     SETTLE_CYCLES = 5 + 3 * MAX_FEATURES + 1 + 60;
    localparam longint CYCLE_LIMIT   = 1500000;
    localparam longint WEIGHT_MAX    = 64'sd2147483647;
    localparam longint WEIGHT_MIN    = -64'sd2147483648;

    // one result word: prediction in bit 0, length flag in bit 1
    typedef struct packed
    {
        logic length_error;
        logic prediction;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own weights, bias and sample bookkeeping, turns
    // every accepted feature word into an expected verdict at the last word.
    // ------------------------------------------------------------------------
    class perceptron_scoreboard;
        logic signed [W_W-1:0] weight [MAX_FEATURES];
        logic signed [W_W-1:0] bias;
        logic signed [X_W-1:0] held_x [MAX_FEATURES];
        int unsigned           elems;
        longint                acc;       // Q27.28 running dot product
        logic [FC_W-1:0]       feat_count;
        logic [LR_W-1:0]       rate;
        verdict_t              pending_q [$];
        int                    errors;
        int                    words;
        int                    results;
        int                    updates;
        int                    flagged;

        function new();
            for (int i = 0; i < MAX_FEATURES; i++)
            begin
                weight[i] = '0;
                held_x[i] = '0;
            end
            bias       = '0;
            elems      = 0;
            acc        = 0;
            feat_count = ppt_pkg::FC_RESET;
            rate       = ppt_pkg::LR_RESET;
            errors     = 0;
            words      = 0;
            results    = 0;
            updates    = 0;
            flagged    = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch @%0t: %s", $time, what);
        endtask

        function void set_reg(input logic idx, input logic [31:0] value);
            case (idx)
                ppt_pkg::REG_FEATURE_COUNT: feat_count = value[FC_W-1:0];
                ppt_pkg::REG_LEARNING_RATE: rate = value[LR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [W_W-1:0] clamp_add(input logic signed [W_W-1:0] a,
                                                  input longint d);
            longint s;
            s = longint'(a) + d;
            if (s > WEIGHT_MAX)
                s = WEIGHT_MAX;
            else if (s < WEIGHT_MIN)
                s = WEIGHT_MIN;
            return s[W_W-1:0];
        endfunction

        function void note_word(input bit cmd, input logic [X_W-1:0] x,
                                input bit last, input bit label);
            logic signed [X_W-1:0] xs;
            longint                total;
            longint                step;
            bit                    pred;
            bit                    lerr;
            verdict_t              v;
            xs = x;
            words++;
            // past the end of the store nothing is kept, count sticks one over
            if (elems < MAX_FEATURES)
            begin
                held_x[elems] = xs;
                acc += longint'(weight[elems]) * longint'(xs);
            end
            if (elems <= MAX_FEATURES)
                elems++;
            if (!last)
                return;
            total = acc + longint'(bias) * 4096;
            pred  = (total >= 0);
            lerr  = (feat_count == 0) || (feat_count > MAX_FEATURES) ||
                    (elems != feat_count);
            if (cmd && !lerr && (pred != label))
            begin
                step = label ? longint'(rate) : -longint'(rate);
                // round to nearest Q15.16, ties up; >>> on longint floors
                for (int i = 0; i < feat_count; i++)
                    weight[i] = clamp_add(weight[i],
                                          (step * longint'(held_x[i]) + 2048) >>> 12);
                bias = clamp_add(bias, step);
                updates++;
            end
            if (lerr)
                flagged++;
            v.prediction   = pred;
            v.length_error = lerr;
            pending_q.push_back(v);
            elems = 0;
            acc   = 0;
        endfunction

        task check_result(input logic pred, input logic lerr);
            verdict_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("result pred=%0b len_err=%0b with nothing pending",
                                 pred, lerr));
                return;
            end
            want = pending_q.pop_front();
            results++;
            if (pred !== want.prediction)
                report($sformatf("result %0d prediction %0b, want %0b",
                                 results, pred, want.prediction));
            if (lerr !== want.length_error)
                report($sformatf("result %0d length_error %0b, want %0b",
                                 results, lerr, want.length_error));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // [15:0] feature, [16] label
    logic        s_axis_tlast;
    logic        s_axis_tuser;     // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [0] prediction, [1] length_error

    perceptron_predict_train_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    perceptron_scoreboard sb;
    longint               cycles;
    int                   stall_left;
    int                   idle_before;   // sender gap ahead of the next word
    int                   settings;
    bit                   calm;          // no idling on either side

    always #HALF_PERIOD clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int sender_gap();
        if (calm || ($urandom_range(0, 2) != 0))
            return 0;
        return pick_gap();
    endfunction

    // extremes and sign boundaries show up often, the rest is uniform
    function automatic logic [X_W-1:0] pick_feature();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, and every accepted word is checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else if (!calm && ($urandom_range(0, 3) == 0))
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap();
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[0], m_axis_tdata[1]);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One feature word. tvalid stays up into the next word when no gap follows,
    // so it is lowered only at an accept that is followed by idle cycles.
    task automatic send_word(input bit cmd, input logic [X_W-1:0] x,
                             input bit last, input bit label);
        repeat (idle_before) @(posedge clk);
        s_axis_tdata  <= {7'd0, label, x};
        s_axis_tlast  <= last;
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(cmd, x, last, label);
        idle_before = sender_gap();
        if (idle_before != 0)
            s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_pair(input bit cmd, input bit label,
                             input logic [X_W-1:0] x0, input logic [X_W-1:0] x1);
        send_word(1'b0, x0, 1'b0, 1'b0);
        send_word(cmd, x1, 1'b1, label);
    endtask

    // park the stream and wait for every pending verdict
    task automatic drain();
        if (idle_before == 0)
            s_axis_tvalid <= 1'b0;
        idle_before = 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // drained, then long enough for a full training pass to finish
    task automatic quiesce();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write with a read-back; pready is tied high so no wait states
    task automatic reg_write(input logic idx, input logic [31:0] value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== value)
            sb.report($sformatf("register %0d reads 0x%08h, wrote 0x%08h", idx, got, value));
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [FC_W-1:0] fc, input logic [LR_W-1:0] lr);
        quiesce();
        reg_write(ppt_pkg::REG_FEATURE_COUNT, {25'd0, fc});
        reg_write(ppt_pkg::REG_LEARNING_RATE, {16'd0, lr});
        settings++;
    endtask

    // Random phase: mostly samples of the configured length, some one short
    // or one long, some arbitrary, and rarely one running past the store.
    task automatic run_phase(input logic [FC_W-1:0] fc, input logic [LR_W-1:0] lr,
                             input int budget, input bit calm_mode);
        int sent;
        int len;
        int k;
        bit fc_ok;
        apply_settings(fc, lr);
        calm  = calm_mode;
        sent  = 0;
        fc_ok = (fc >= 1) && (fc <= MAX_FEATURES);
        while (sent < budget)
        begin
            k = $urandom_range(0, 19);
            if (k < 14)
                len = fc_ok ? fc : $urandom_range(1, 8);
            else if (k == 14)
                len = (fc > 1) ? fc - 1 : 2;
            else if (k == 15)
                len = fc + 1;
            else if ((k == 19) && ($urandom_range(0, 3) == 0))
                len = $urandom_range(MAX_FEATURES + 1, MAX_FEATURES + 6);
            else
                len = $urandom_range(1, 10);
            for (int j = 0; j < len; j++)
            begin
                if (j == len - 1)
                    send_word($urandom_range(0, 3) != 0, pick_feature(), 1'b1,
                              1'($urandom_range(0, 1)));
                else
                    send_word(1'($urandom_range(0, 1)), pick_feature(), 1'b0,
                              1'($urandom_range(0, 1)));
            end
            sent += len;
            // now and then hold off until the block has answered everything
            if (!calm && ($urandom_range(0, 24) == 0))
                drain();
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cycles        = 0;
        stall_left    = 0;
        idle_before   = 0;
        settings      = 1;
        calm          = 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, on the reset settings (two features, rate 6554)
        send_pair(1'b0, 1'b0, 16'h7fff, 16'h8000);   // zero weights: sum 0 gives class 1
        send_pair(1'b1, 1'b0, 16'h7fff, 16'h8000);   // wrong, bias and weight 0 move down, weight 1 up
        send_pair(1'b1, 1'b0, 16'h7fff, 16'h8000);   // now right, nothing changes
        send_pair(1'b1, 1'b1, 16'h7fff, 16'h8000);   // wrong the other way
        send_pair(1'b0, 1'b1, 16'h0000, 16'hffff);
        send_word(1'b1, 16'h1234, 1'b1, 1'b0);       // one short: flagged, no training
        send_word(1'b0, 16'h8000, 1'b0, 1'b1);       // one long
        send_word(1'b1, 16'h7fff, 1'b0, 1'b0);
        send_word(1'b1, 16'h4000, 1'b1, 1'b1);

        // feature counts that no sample can match
        apply_settings(7'd0, ppt_pkg::LR_RESET);
        send_word(1'b1, 16'h7fff, 1'b1, 1'b0);
        apply_settings(7'd127, ppt_pkg::LR_RESET);
        send_word(1'b1, 16'h8000, 1'b1, 1'b0);

        // single feature, largest and zero step
        apply_settings(7'd1, 16'hffff);
        send_word(1'b1, 16'h8000, 1'b1, 1'b1);
        send_word(1'b1, 16'h7fff, 1'b1, 1'b0);
        send_word(1'b1, 16'h7fff, 1'b1, 1'b0);
        apply_settings(7'd1, 16'h0000);
        send_word(1'b1, 16'h8000, 1'b1, 1'b1);
        send_word(1'b1, 16'h7fff, 1'b1, 1'b0);

        // random phases over a spread of settings
        run_phase(7'd3, 16'($urandom_range(0, 16'hffff)), 300, 1'b0);
        run_phase(7'd1, 16'hffff, 200, 1'b0);
        run_phase(7'd64, 16'd1, 200, 1'b0);
        run_phase(7'd2, 16'd0, 150, 1'b1);
        run_phase(7'd8, 16'($urandom_range(0, 16'hffff)), 300, 1'b0);
        run_phase(7'd65, 16'($urandom_range(0, 16'hffff)), 100, 1'b0);
        run_phase(7'($urandom_range(1, 6)), 16'($urandom_range(0, 16'hffff)), 300, 1'b1);
        run_phase(7'd5, 16'h8000, 300, 1'b0);

        // tail: let any late training pass or stray word show up
        quiesce();

        $display("run covered %0d feature words and %0d result words over %0d settings",
                 sb.words, sb.results, settings);
        $display("%0d training updates applied, %0d samples flagged for length",
                 sb.updates, sb.flagged);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ perceptron_predict_train_top.f @@
+incdir+rtl
rtl/ppt_pkg.sv
rtl/perceptron_predict_train_top.sv
test/perceptron_predict_train_top_tb.sv
